FILE: hw/rtl/mff_pkg.sv
package mff_pkg;

  // Item geometry
  localparam int PHASES       = 4;
  localparam int ADC_BITS     = 12;
  localparam int ENCODER_BITS = 16;

  // Field and state widths
  localparam int FUNC_W     = 2;
  localparam int CPR_W      = 16;
  localparam int POLES_W    = 7;
  localparam int GAIN_W     = 16;
  localparam int NSAMP_W    = 16;
  localparam int SUM_W      = 28;
  localparam int OFS_W      = 16;
  localparam int FRAC_BITS  = 4;
  localparam int CUR_W      = 16;
  localparam int VOLT_W     = 16;
  localparam int SPEED_W    = 32;
  localparam int SPEED_FRAC = 16;

  // Datapath widths
  localparam int RAWQ_W     = ADC_BITS + FRAC_BITS;
  localparam int DIFF_W     = ((RAWQ_W > OFS_W) ? RAWQ_W : OFS_W) + 1;
  localparam int CUR_PROD_W = DIFF_W + GAIN_W;
  localparam int CUR_SHIFT  = FRAC_BITS + GAIN_W;
  localparam int VOLT_A_W   = ADC_BITS + 1;
  localparam int VOLT_PROD_W = VOLT_A_W + GAIN_W;
  localparam int D_W        = CPR_W + 2;
  localparam int E_W        = D_W + SPEED_FRAC + 1;
  localparam int SPD_PROD_W = E_W + GAIN_W;
  localparam int CAL_N      = SUM_W + FRAC_BITS;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_MEASURE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CAL     = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_ZERO    = 2'd3;

  // Register map
  localparam int IDX_W  = 3;
  localparam int ADDR_W = IDX_W + 2;
  localparam int DATA_W = 32;
  localparam logic [IDX_W-1:0] REG_CPR       = 3'd0;
  localparam logic [IDX_W-1:0] REG_POLES     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CUR_GAIN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_VOLT_GAIN = 3'd3;
  localparam logic [IDX_W-1:0] REG_SPD_COEFF = 3'd4;

  typedef struct packed {
    logic [CPR_W-1:0]   cpr;
    logic [POLES_W-1:0] poles;
    logic [GAIN_W-1:0]  cur_gain;
    logic [GAIN_W-1:0]  volt_gain;
    logic [GAIN_W-1:0]  spd_coeff;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cpr:       16'd4096,
    poles:     7'd6,
    cur_gain:  16'd4096,
    volt_gain: 16'd4096,
    spd_coeff: 16'd3277
  };

  // 2048.0 in Q12.4
  localparam logic [OFS_W-1:0] OFS_RESET = 16'd32768;

endpackage

FILE: hw/rtl/mff_stream_if.sv
interface mff_in_if import mff_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [ADC_BITS-1:0]     phase_a_raw;
  logic [ADC_BITS-1:0]     phase_b_raw;
  logic [ADC_BITS-1:0]     phase_c_raw;
  logic [ADC_BITS-1:0]     phase_d_raw;
  logic [ADC_BITS-1:0]     bus_voltage_raw;
  logic [ENCODER_BITS-1:0] encoder_count;
  logic [NSAMP_W-1:0]      sample_count;

  modport source (
    output valid, func, phase_a_raw, phase_b_raw, phase_c_raw, phase_d_raw,
           bus_voltage_raw, encoder_count, sample_count,
    input  ready
  );
  modport sink (
    input  valid, func, phase_a_raw, phase_b_raw, phase_c_raw, phase_d_raw,
           bus_voltage_raw, encoder_count, sample_count,
    output ready
  );
endinterface

interface mff_out_if import mff_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CUR_W-1:0]    phase_a_current;
  logic signed [CUR_W-1:0]    phase_b_current;
  logic signed [CUR_W-1:0]    phase_c_current;
  logic signed [CUR_W-1:0]    phase_d_current;
  logic [VOLT_W-1:0]          bus_voltage;
  logic [CPR_W-1:0]           rotor_angle;
  logic signed [SPEED_W-1:0]  rotor_speed;

  modport source (
    output valid, phase_a_current, phase_b_current, phase_c_current, phase_d_current,
           bus_voltage, rotor_angle, rotor_speed,
    input  ready
  );
  modport sink (
    input  valid, phase_a_current, phase_b_current, phase_c_current, phase_d_current,
           bus_voltage, rotor_angle, rotor_speed,
    output ready
  );
endinterface

FILE: hw/rtl/mff_div_lane.sv
module mff_div_lane #(
  parameter int N = 16,
  parameter int M = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  output logic         busy,
  output logic [N-1:0] quot,
  output logic [M-1:0] rem
);

  localparam int CW = (N > 1) ? $clog2(N) : 1;
  localparam logic [CW-1:0] LAST = CW'(N - 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [N-1:0]  q_r;
  logic [M-1:0]  r_r;
  logic [M-1:0]  d_r;
  logic [M+1:0]  trial;
  logic          ge;
  logic [M-1:0]  r_nxt;

  // Trial subtract of the divisor from the partial remainder with the next dividend bit
  always_comb begin
    trial = {1'b0, r_r, q_r[N-1]} - {2'b00, d_r};
    ge    = ~trial[M+1];
    r_nxt = ge ? trial[M-1:0] : {r_r[M-2:0], q_r[N-1]};
  end

  // Step counter: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift dividend bits out and quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= {q_r[N-2:0], ge};
      r_r <= r_nxt;
    end
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

FILE: hw/rtl/mff_mul_lane.sv
module mff_mul_lane #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  output logic                 busy,
  output logic signed [AW+BW-1:0] prod
);

  localparam int CW = (BW > 1) ? $clog2(BW) : 1;
  localparam logic [CW-1:0] LAST = CW'(BW - 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] a_r;
  logic [AW+BW-1:0] p_r;
  logic [AW:0]   sum;

  // Add the multiplicand to the upper half when the low multiplier bit is set
  always_comb begin
    sum = {p_r[AW+BW-1], p_r[AW+BW-1:BW]}
        + (p_r[0] ? {a_r[AW-1], a_r} : {(AW+1){1'b0}});
  end

  // Step counter: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Shift the partial product right, retiring one multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      p_r <= {{AW{1'b0}}, b};
    end else if (busy_r) begin
      p_r <= {sum, p_r[BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign prod = signed'(p_r);

endmodule

FILE: hw/rtl/mff_regs.sv
module mff_regs import mff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t             cfg_r;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_CPR:       cfg_r.cpr       <= pwdata[CPR_W-1:0];
        REG_POLES:     cfg_r.poles     <= pwdata[POLES_W-1:0];
        REG_CUR_GAIN:  cfg_r.cur_gain  <= pwdata[GAIN_W-1:0];
        REG_VOLT_GAIN: cfg_r.volt_gain <= pwdata[GAIN_W-1:0];
        REG_SPD_COEFF: cfg_r.spd_coeff <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_CPR:       prdata = DATA_W'(cfg_r.cpr);
      REG_POLES:     prdata = DATA_W'(cfg_r.poles);
      REG_CUR_GAIN:  prdata = DATA_W'(cfg_r.cur_gain);
      REG_VOLT_GAIN: prdata = DATA_W'(cfg_r.volt_gain);
      REG_SPD_COEFF: prdata = DATA_W'(cfg_r.spd_coeff);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/motor_feedback_frontend_core.sv
// Measure item: accept, prepare, divide, start the multiplies, then load the output
// register; the next item is taken after that load, later while an earlier result still waits in the output register.
// Calibration, capture and clear items return to idle with no output; a calibration
// item with a zero sample count skips the divider. Serial lanes, one bit per cycle: 16-step encoder
// modulo, 32-step offset divider, 16-step multipliers. rst_n (synchronous, active low)
// restores register defaults, offsets to 2048.0, clears sums, zero, count, speed, output.
module motor_feedback_frontend_core import mff_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  mff_in_if.sink            in_if,
  mff_out_if.source         out_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MST  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;

  localparam logic signed [E_W:0] SPD_MAX = {{(E_W + 2 - SPEED_W){1'b0}}, {(SPEED_W-1){1'b1}}};
  localparam logic signed [E_W:0] SPD_MIN = {{(E_W + 2 - SPEED_W){1'b1}}, {(SPEED_W-1){1'b0}}};

  cfg_t cfg;

  logic [2:0] state_r, state_nxt;
  logic       in_acc;

  // Latched item
  logic [FUNC_W-1:0]       func_r;
  logic [ADC_BITS-1:0]     raw_r [PHASES];
  logic [ADC_BITS-1:0]     vraw_r;
  logic [ENCODER_BITS-1:0] enc_r;
  logic [NSAMP_W-1:0]      nsamp_r;

  // Block state
  logic [OFS_W-1:0]          ofs_r [PHASES];
  logic [SUM_W-1:0]          sum_r [PHASES];
  logic [SUM_W-1:0]          sum_add [PHASES];
  logic [CPR_W-1:0]          prev_r;
  logic [CPR_W-1:0]          azero_r;
  logic signed [SPEED_W-1:0] fs_r;

  // Measure intermediates
  logic [CPR_W-1:0]      angle_r;
  logic signed [D_W-1:0] dlt_r;

  // Output register
  logic                      out_valid_r;
  logic signed [CUR_W-1:0]   cur_out_r [PHASES];
  logic [VOLT_W-1:0]         volt_out_r;
  logic [CPR_W-1:0]          angle_out_r;
  logic signed [SPEED_W-1:0] speed_out_r;

  // Lane handshakes
  logic                div_start, cal_start, mul_start;
  logic                enc_busy, az_busy, align_busy;
  logic [PHASES-1:0]   cal_busy;
  logic [PHASES-1:0]   cur_busy;
  logic                volt_busy, spd_busy;
  logic                div_busy, mul_busy, div_done, finish;

  // Lane results
  logic [ENCODER_BITS-1:0] enc_quot;
  logic [CPR_W-1:0]        enc_rem;
  logic [CPR_W-1:0]        az_quot;
  logic [CPR_W-1:0]        az_rem;
  logic [CPR_W-1:0]        align_quot;
  logic [POLES_W:0]        align_rem;
  logic [CAL_N-1:0]        cal_quot [PHASES];
  logic [NSAMP_W-1:0]      cal_rem [PHASES];
  logic signed [CUR_PROD_W-1:0]  cur_prod [PHASES];
  logic signed [VOLT_PROD_W-1:0] volt_prod;
  logic signed [SPD_PROD_W-1:0]  spd_prod;

  // Effective configuration
  logic [CPR_W-1:0]   cpr_eff;
  logic [POLES_W-1:0] poles_eff;
  logic [POLES_W:0]   pole_div;

  // Combinational datapath
  logic [CPR_W-1:0]      cnt;
  logic [CPR_W-1:0]      angle_nxt;
  logic [CPR_W-1:0]      azero_nxt;
  logic signed [D_W-1:0] d0, d1, d2, half_s, cpr_s;
  logic signed [DIFF_W-1:0] diff [PHASES];
  logic signed [VOLT_A_W-1:0] volt_a;
  logic signed [E_W-1:0] err;
  logic signed [E_W-1:0] spd_step;
  logic signed [E_W:0]   spd_sum;
  logic signed [SPEED_W-1:0] spd_sat;
  logic signed [CUR_PROD_W-CUR_SHIFT-1:0] cur_val [PHASES];

  mff_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign cpr_eff   = (cfg.cpr < CPR_W'(2)) ? CPR_W'(2) : cfg.cpr;
  assign poles_eff = (cfg.poles == '0) ? POLES_W'(1) : cfg.poles;
  assign pole_div  = {poles_eff, 1'b0};

  assign in_acc       = in_if.valid & in_if.ready;
  assign in_if.ready  = (state_r == S_IDLE);

  assign div_start = (state_r == S_PREP) && ((func_r == FUNC_MEASURE) || (func_r == FUNC_ZERO));
  assign cal_start = (state_r == S_PREP) && (func_r == FUNC_CAL) && (nsamp_r != '0);
  assign mul_start = (state_r == S_MST);

  assign div_busy = enc_busy | az_busy | align_busy | (|cal_busy);
  assign mul_busy = (|cur_busy) | volt_busy | spd_busy;
  assign div_done = (state_r == S_DIV) && !div_busy;
  assign finish   = (state_r == S_MUL) && !mul_busy && (!out_valid_r || out_if.ready);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_PREP;
      S_PREP: begin
        priority if (div_start || cal_start) state_nxt = S_DIV;
        else state_nxt = S_IDLE;
      end
      S_DIV:  if (div_done) state_nxt = (func_r == FUNC_MEASURE) ? S_MST : S_IDLE;
      S_MST:  state_nxt = S_MUL;
      S_MUL:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Encoder count modulo the revolution, angle zero modulo the revolution, alignment
  mff_div_lane #(.N(ENCODER_BITS), .M(CPR_W)) u_enc_mod (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (enc_r), .divisor (cpr_eff),
    .busy (enc_busy), .quot (enc_quot), .rem (enc_rem)
  );

  mff_div_lane #(.N(CPR_W), .M(CPR_W)) u_az_mod (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (azero_r), .divisor (cpr_eff),
    .busy (az_busy), .quot (az_quot), .rem (az_rem)
  );

  mff_div_lane #(.N(CPR_W), .M(POLES_W + 1)) u_align_div (
    .clk (clk), .rst_n (rst_n), .start (div_start),
    .dividend (cpr_eff), .divisor (pole_div),
    .busy (align_busy), .quot (align_quot), .rem (align_rem)
  );

  // Calibration sums and offset dividers, one per phase
  for (genvar k = 0; k < PHASES; k++) begin : g_cal
    assign sum_add[k] = sum_r[k] + SUM_W'(raw_r[k]);

    mff_div_lane #(.N(CAL_N), .M(NSAMP_W)) u_cal_div (
      .clk (clk), .rst_n (rst_n), .start (cal_start),
      .dividend ({sum_add[k], {FRAC_BITS{1'b0}}}), .divisor (nsamp_r),
      .busy (cal_busy[k]), .quot (cal_quot[k]), .rem (cal_rem[k])
    );
  end

  // Angle and wrapped count delta once the modulo lanes finish
  always_comb begin
    cnt       = enc_rem;
    angle_nxt = cnt - az_rem + ((cnt >= az_rem) ? '0 : cpr_eff);
    azero_nxt = cnt - align_quot + ((cnt >= align_quot) ? '0 : cpr_eff);
    half_s    = D_W'(cpr_eff >> 1);
    cpr_s     = D_W'(cpr_eff);
    d0        = D_W'(cnt) - D_W'(prev_r);
    d1        = (d0 > half_s) ? d0 - cpr_s : d0;
    d2        = (d1 < -half_s) ? d1 + cpr_s : d1;
  end

  // Multiplier operands
  always_comb begin
    volt_a = VOLT_A_W'(vraw_r);
    err    = {{(E_W - D_W - SPEED_FRAC){dlt_r[D_W-1]}}, dlt_r, {SPEED_FRAC{1'b0}}}
           - E_W'(fs_r);
  end

  for (genvar k = 0; k < PHASES; k++) begin : g_cur
    assign diff[k] = DIFF_W'({raw_r[k], {FRAC_BITS{1'b0}}}) - DIFF_W'(ofs_r[k]);

    mff_mul_lane #(.AW(DIFF_W), .BW(GAIN_W)) u_cur_mul (
      .clk (clk), .rst_n (rst_n), .start (mul_start),
      .a (diff[k]), .b (cfg.cur_gain),
      .busy (cur_busy[k]), .prod (cur_prod[k])
    );

    // Floor shift; the shifted product always fits the output width
    assign cur_val[k] = cur_prod[k][CUR_PROD_W-1:CUR_SHIFT];
  end

  mff_mul_lane #(.AW(VOLT_A_W), .BW(GAIN_W)) u_volt_mul (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .a (volt_a), .b (cfg.volt_gain),
    .busy (volt_busy), .prod (volt_prod)
  );

  mff_mul_lane #(.AW(E_W), .BW(GAIN_W)) u_spd_mul (
    .clk (clk), .rst_n (rst_n), .start (mul_start),
    .a (err), .b (cfg.spd_coeff),
    .busy (spd_busy), .prod (spd_prod)
  );

  // Low-pass update with saturation to the speed width
  always_comb begin
    spd_step = spd_prod[SPD_PROD_W-1:SPEED_FRAC];
    spd_sum  = (E_W+1)'(fs_r) + (E_W+1)'(spd_step);
    priority if (spd_sum > SPD_MAX) spd_sat = SPD_MAX[SPEED_W-1:0];
    else if (spd_sum < SPD_MIN)     spd_sat = SPD_MIN[SPEED_W-1:0];
    else                            spd_sat = spd_sum[SPEED_W-1:0];
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r   <= in_if.func;
      raw_r[0] <= in_if.phase_a_raw;
      raw_r[1] <= in_if.phase_b_raw;
      raw_r[2] <= in_if.phase_c_raw;
      raw_r[3] <= in_if.phase_d_raw;
      vraw_r   <= in_if.bus_voltage_raw;
      enc_r    <= in_if.encoder_count;
      nsamp_r  <= in_if.sample_count;
    end
  end

  // Calibration state
  always_ff @(posedge clk) begin
    for (int k = 0; k < PHASES; k++) begin
      if (!rst_n) begin
        sum_r[k] <= '0;
        ofs_r[k] <= OFS_RESET;
      end else begin
        if (state_r == S_PREP && func_r == FUNC_CLEAR) begin
          sum_r[k] <= '0;
        end else if (state_r == S_PREP && func_r == FUNC_CAL) begin
          sum_r[k] <= sum_add[k];
        end
        if (div_done && func_r == FUNC_CAL) begin
          ofs_r[k] <= (|cal_quot[k][CAL_N-1:OFS_W]) ? {OFS_W{1'b1}} : cal_quot[k][OFS_W-1:0];
        end
      end
    end
  end

  // Position and speed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      azero_r <= '0;
      fs_r    <= '0;
    end else begin
      if (div_done && func_r == FUNC_ZERO) begin
        azero_r <= azero_nxt;
        prev_r  <= cnt;
        fs_r    <= '0;
      end else if (div_done && func_r == FUNC_MEASURE) begin
        prev_r <= cnt;
      end
      if (finish) begin
        fs_r <= spd_sat;
      end
    end
  end

  // Hold angle and delta for the multiply phase
  always_ff @(posedge clk) begin
    if (div_done) begin
      angle_r <= angle_nxt;
      dlt_r   <= d2;
    end
  end

  // Output register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      for (int k = 0; k < PHASES; k++) begin
        cur_out_r[k] <= CUR_W'(cur_val[k]);
      end
      volt_out_r  <= VOLT_W'(volt_prod[ADC_BITS+GAIN_W-1:GAIN_W]);
      angle_out_r <= angle_r;
      speed_out_r <= spd_sat;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.phase_a_current = cur_out_r[0];
  assign out_if.phase_b_current = cur_out_r[1];
  assign out_if.phase_c_current = cur_out_r[2];
  assign out_if.phase_d_current = cur_out_r[3];
  assign out_if.bus_voltage     = volt_out_r;
  assign out_if.rotor_angle     = angle_out_r;
  assign out_if.rotor_speed     = speed_out_r;

endmodule

FILE: hw/rtl/mff_checker.sv
module mff_checker import mff_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FUNC_W-1:0]  in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CPR_W-1:0]   out_angle,
  input logic [SPEED_W-1:0] out_speed
);

  logic [1:0] pend_r;
  logic       in_meas;
  logic       out_acc;

  assign in_meas = in_valid & in_ready & (in_func == FUNC_MEASURE);
  assign out_acc = out_valid & out_ready;

  // Count measure items whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_meas && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_meas) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  // One item at a time: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready stayed high after an accepted item");

  // Every result belongs to an accepted measure item
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> pend_r != 2'd0)
    else $error("result delivered without a pending measure item");

  // At most one result in flight plus one waiting
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two measure results outstanding");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_speed))
    else $error("stalled result changed or dropped");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind motor_feedback_frontend_core mff_checker u_mff_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .in_func   (in_if.func),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_angle (out_if.rotor_angle),
  .out_speed (out_if.rotor_speed)
);
